@@ src/dkg_pkg.sv @@
// Shared types and constants of the batch duplicate key grouper.
package dkg_pkg;

  localparam int HASH_W  = 64;
  localparam int KEY_W   = 64;
  localparam int TUPLE_W = 11;

  typedef struct packed {
    logic               found;
    logic [TUPLE_W-1:0] match_tuple;
    logic               table_full;
  } dkg_result_t;

  localparam int RESULT_W = $bits(dkg_result_t);

endpackage

@@ src/dkg_fifo.sv @@
// Two-entry register queue used between the parts of the grouper.
module dkg_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] data_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_nxt;
  logic [1:0]       count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/dkg_front.sv @@
// Front end: accepts items, extracts the directory slot and queues them for the walker.
module dkg_front #(
  parameter int SLOT_W = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [dkg_pkg::HASH_W-1:0]  in_hash_value,
  input  logic [dkg_pkg::KEY_W-1:0]   in_key_value,
  input  logic [dkg_pkg::TUPLE_W-1:0] in_tuple_index,
  input  logic                       in_start_batch,
  input  logic                       q_pop,
  output logic                       q_empty,
  output logic [SLOT_W-1:0]          q_slot,
  output logic [dkg_pkg::KEY_W-1:0]   q_key,
  output logic [dkg_pkg::TUPLE_W-1:0] q_tuple,
  output logic                       q_start
);

  import dkg_pkg::*;

  localparam int ITEM_W = SLOT_W + KEY_W + TUPLE_W + 1;

  logic [ITEM_W-1:0] push_item;
  logic [ITEM_W-1:0] pop_item;

  assign push_item = {in_hash_value[SLOT_W-1:0], in_key_value, in_tuple_index, in_start_batch};
  assign {q_slot, q_key, q_tuple, q_start} = pop_item;

  dkg_fifo #(
    .WIDTH(ITEM_W)
  ) u_item_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_data(push_item),
    .full     (in_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_data (pop_item)
  );

endmodule

@@ src/dkg_back.sv @@
// Back end: walks the hash chain of one item in memory and inserts new keys at the head.
module dkg_back #(
  parameter int BATCH_SIZE = 2048,
  parameter int SLOT_W     = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [SLOT_W-1:0]          q_slot,
  input  logic [dkg_pkg::KEY_W-1:0]   q_key,
  input  logic [dkg_pkg::TUPLE_W-1:0] q_tuple,
  input  logic                       q_start,
  input  logic                       res_full,
  output logic                       res_push,
  output dkg_pkg::dkg_result_t        res_data
);

  import dkg_pkg::*;

  localparam int IDX_W = $clog2(BATCH_SIZE);
  localparam int SLOTS = 1 << SLOT_W;
  localparam logic [IDX_W:0] BATCH_CNT = (IDX_W + 1)'(BATCH_SIZE);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HEAD  = 2'd1;
  localparam logic [1:0] ST_ENTRY = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TUPLE_W-1:0] tuple;
    logic               has_next;
    logic [IDX_W-1:0]   next;
    logic [SLOT_W-1:0]  slot;
  } entry_t;

  logic [IDX_W-1:0] head_mem [SLOTS];
  entry_t           ent_mem  [BATCH_SIZE];

  logic [1:0]         state_r,    state_nxt;
  logic [IDX_W:0]     used_r,     used_nxt;
  logic               first_r,    first_nxt;
  logic [IDX_W-1:0]   head_idx_r, head_idx_nxt;
  logic [SLOT_W-1:0]  slot_r;
  logic [KEY_W-1:0]   key_r;
  logic [TUPLE_W-1:0] tuple_r;
  logic [IDX_W-1:0]   head_rdata_r;
  entry_t             ent_rdata_r;

  logic               take;
  logic               head_we;
  logic               ent_we;
  logic               ent_re;
  logic [IDX_W-1:0]   ent_raddr;
  entry_t             ent_wdata;
  logic               cand_ok;
  logic               hit;

  assign take    = (state_r == ST_IDLE) && !q_empty && !res_full;
  assign q_pop   = take;
  assign cand_ok = first_r ? (({1'b0, head_idx_r} < used_r) && (ent_rdata_r.slot == slot_r))
                           : 1'b1;
  assign hit     = cand_ok && (ent_rdata_r.key == key_r);

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    first_nxt    = first_r;
    head_idx_nxt = head_idx_r;
    head_we      = 1'b0;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_raddr    = head_rdata_r;
    res_push     = 1'b0;
    res_data     = '0;
    ent_wdata.key      = key_r;
    ent_wdata.tuple    = tuple_r;
    ent_wdata.has_next = first_r ? cand_ok : 1'b1;
    ent_wdata.next     = head_idx_r;
    ent_wdata.slot     = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_start) begin
            used_nxt = '0;
          end
          first_nxt = 1'b1;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        head_idx_nxt = head_rdata_r;
        ent_re       = 1'b1;
        ent_raddr    = head_rdata_r;
        state_nxt    = ST_ENTRY;
      end
      ST_ENTRY: begin
        if (hit) begin
          res_push             = 1'b1;
          res_data.found       = 1'b1;
          res_data.match_tuple = ent_rdata_r.tuple;
          state_nxt            = ST_IDLE;
        end else if (cand_ok && ent_rdata_r.has_next) begin
          ent_re    = 1'b1;
          ent_raddr = ent_rdata_r.next;
          first_nxt = 1'b0;
        end else begin
          res_push             = 1'b1;
          res_data.match_tuple = tuple_r;
          if (used_r >= BATCH_CNT) begin
            res_data.table_full = 1'b1;
          end else begin
            ent_we   = 1'b1;
            head_we  = 1'b1;
            used_nxt = used_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      used_r     <= '0;
      first_r    <= 1'b1;
      head_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      first_r    <= first_nxt;
      head_idx_r <= head_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot_r  <= q_slot;
      key_r   <= q_key;
      tuple_r <= q_tuple;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      head_rdata_r <= head_mem[q_slot];
    end
    if (head_we) begin
      head_mem[slot_r] <= used_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_re) begin
      ent_rdata_r <= ent_mem[ent_raddr];
    end
    if (ent_we) begin
      ent_mem[used_r[IDX_W-1:0]] <= ent_wdata;
    end
  end

endmodule

@@ src/batch_duplicate_key_grouper_unit.sv @@
// Top level of the batch duplicate key grouper.
// Each accepted transaction carries a hash, a 64-bit key and a tuple index, and produces one
// result transaction that tells whether an earlier tuple of the batch has the same key (and which
// one), or that the key was recorded as a new group, or that storage was full. Items queue in a
// two-entry front buffer and results in a two-entry output buffer, so both sides may stall freely.
// The chain walker takes no new item until the current one is done, and it steps down the chain
// one entry at a time through the registered reads of the directory and entry memories. A start of batch
// empties the table at once: no clearing pass runs after reset or between batches, since a
// directory entry counts only if it points below the fill count at an entry of the same slot.
module batch_duplicate_key_grouper_unit #(
  parameter int BATCH_SIZE      = 2048,
  parameter int DIRECTORY_SLOTS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [dkg_pkg::HASH_W-1:0]  in_hash_value,
  input  logic [dkg_pkg::KEY_W-1:0]   in_key_value,
  input  logic [dkg_pkg::TUPLE_W-1:0] in_tuple_index,
  input  logic                        in_start_batch,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_found,
  output logic [dkg_pkg::TUPLE_W-1:0] out_match_tuple,
  output logic                        out_table_full
);

  import dkg_pkg::*;

  localparam int SLOT_W = $clog2(DIRECTORY_SLOTS);

  logic               q_pop;
  logic               q_empty;
  logic [SLOT_W-1:0]  q_slot;
  logic [KEY_W-1:0]   q_key;
  logic [TUPLE_W-1:0] q_tuple;
  logic               q_start;
  logic               res_push;
  logic               res_full;
  dkg_result_t        res_data;
  dkg_result_t        out_res;

  dkg_front #(
    .SLOT_W(SLOT_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_hash_value (in_hash_value),
    .in_key_value  (in_key_value),
    .in_tuple_index(in_tuple_index),
    .in_start_batch(in_start_batch),
    .q_pop         (q_pop),
    .q_empty       (q_empty),
    .q_slot        (q_slot),
    .q_key         (q_key),
    .q_tuple       (q_tuple),
    .q_start       (q_start)
  );

  dkg_back #(
    .BATCH_SIZE(BATCH_SIZE),
    .SLOT_W    (SLOT_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_slot  (q_slot),
    .q_key   (q_key),
    .q_tuple (q_tuple),
    .q_start (q_start),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_data)
  );

  dkg_fifo #(
    .WIDTH(RESULT_W)
  ) u_result_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .full     (res_full),
    .pop      (out_pop),
    .empty    (out_empty),
    .pop_data (out_res)
  );

  assign out_found       = out_res.found;
  assign out_match_tuple = out_res.match_tuple;
  assign out_table_full  = out_res.table_full;

`ifndef SYNTHESIS
  a_result_room: assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
    else $error("Result written while the result queue is full.");
  a_item_present: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("Walker took an item from an empty item queue.");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> !res_push)
    else $error("Result produced in the cycle after an item was taken.");
  a_full_only_new: assert property (@(posedge clk) disable iff (!rst_n)
      res_push |-> !(res_data.found && res_data.table_full))
    else $error("Result reports both a match and a full table.");
`endif

endmodule
